@@ hdl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset disabled
`define FBFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disabled
`define FBFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fbfl_pkg.sv @@
// Shared constants, codes and control types of the free-list allocator
package fbfl_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int LINK_W     = ADDR_W + 1;
    localparam int GRANT_CAP  = 1024;
    localparam int POOL_CAP   = (POOL_DEPTH < GRANT_CAP) ? POOL_DEPTH : GRANT_CAP;

    localparam int CFG_W   = 11;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;

    localparam logic [LINK_W-1:0]  LINK_NULL = LINK_W'(POOL_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   POOL_BLOCKS_RESET = CFG_W'(1024);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam int PADDR_W = 3;
    localparam logic REG_POOL_BLOCKS = 1'b0;

    typedef enum logic [1:0] {
        ADDR_HEAD,
        ADDR_IDX,
        ADDR_WALK
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_RDATA,
        WD_NULL,
        WD_IDX,
        WD_WALK
    } wdata_sel_t;

    typedef enum logic [1:0] {
        HEAD_HOLD,
        HEAD_RDATA,
        HEAD_IDX,
        HEAD_ZERO
    } head_sel_t;

    typedef struct packed {
        logic       capture;
        logic       ram_we;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        head_sel_t  head_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_ready;
        logic       walk_inc;
        logic       finish;
        logic       ok;
        logic       grant;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pool_ready;
        logic            head_valid;
        logic            head_null;
        logic            idx_valid;
        logic            walk_last;
        logic            pend_full;
        logic            slot_free;
    } dp_stat_t;

endpackage

@@ hdl/fbfl_ram.sv @@
// Generic single-port RAM with registered read
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hdl/fbfl_ctrl.sv @@
// Controller state machine of the free-list allocator
module fbfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fbfl_pkg::dp_stat_t stat,
    output fbfl_pkg::dp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FREE2 = 2'd2;
    localparam logic [1:0] S_INIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE) && (!stat.pend_full || stat.slot_free);

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel  = fbfl_pkg::ADDR_HEAD;
        cmd.wdata_sel = fbfl_pkg::WD_RDATA;
        cmd.head_sel  = fbfl_pkg::HEAD_HOLD;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // keep the head link on the read port so it is ready next cycle
                cmd.capture = in_valid && in_ready;
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (stat.op)
                    fbfl_pkg::OP_ALLOC:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.pool_ready && stat.head_valid)
                        begin
                            cmd.head_sel = fbfl_pkg::HEAD_RDATA;
                            cmd.cnt_inc  = 1'b1;
                            cmd.ok       = 1'b1;
                            cmd.grant    = 1'b1;
                        end
                    end
                    fbfl_pkg::OP_FREE:
                    begin
                        if (stat.pool_ready && stat.idx_valid)
                        begin
                            cmd.ram_we   = 1'b1;
                            cmd.addr_sel = fbfl_pkg::ADDR_IDX;
                            if (stat.head_null)
                            begin
                                cmd.wdata_sel = fbfl_pkg::WD_NULL;
                                cmd.head_sel  = fbfl_pkg::HEAD_IDX;
                                cmd.cnt_dec   = 1'b1;
                                cmd.finish    = 1'b1;
                                cmd.ok        = 1'b1;
                            end
                            else
                            begin
                                // inherit the old successor of the head
                                cmd.wdata_sel = fbfl_pkg::WD_RDATA;
                                state_next    = S_FREE2;
                            end
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                        end
                    end
                    fbfl_pkg::OP_INIT:
                    begin
                        if (stat.pool_ready)
                        begin
                            cmd.finish = 1'b1;
                            cmd.ok     = 1'b1;
                        end
                        else
                        begin
                            state_next = S_INIT;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                    end
                endcase
            end
            S_FREE2:
            begin
                cmd.ram_we    = 1'b1;
                cmd.addr_sel  = fbfl_pkg::ADDR_HEAD;
                cmd.wdata_sel = fbfl_pkg::WD_IDX;
                cmd.cnt_dec   = 1'b1;
                cmd.finish    = 1'b1;
                cmd.ok        = 1'b1;
                state_next    = S_IDLE;
            end
            S_INIT:
            begin
                cmd.ram_we    = 1'b1;
                cmd.addr_sel  = fbfl_pkg::ADDR_WALK;
                cmd.wdata_sel = fbfl_pkg::WD_WALK;
                cmd.walk_inc  = 1'b1;
                if (stat.walk_last)
                begin
                    cmd.head_sel  = fbfl_pkg::HEAD_ZERO;
                    cmd.set_ready = 1'b1;
                    cmd.finish    = 1'b1;
                    cmd.ok        = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/fbfl_dp.sv @@
// Datapath of the free-list allocator: head, count, link RAM and result stages
module fbfl_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [fbfl_pkg::OP_W-1:0]      op,
    input  logic [fbfl_pkg::IDX_W-1:0]     block_index,
    input  logic [fbfl_pkg::CFG_W-1:0]     pool_blocks,
    input  fbfl_pkg::dp_cmd_t              cmd,
    output fbfl_pkg::dp_stat_t             stat,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           ok,
    output logic [fbfl_pkg::IDX_W-1:0]     granted_index,
    output logic [fbfl_pkg::COUNT_W-1:0]   used_blocks
);

    logic [fbfl_pkg::OP_W-1:0]    op_reg;
    logic [fbfl_pkg::IDX_W-1:0]   idx_reg;
    logic [fbfl_pkg::LINK_W-1:0]  head_reg;
    logic [fbfl_pkg::LINK_W-1:0]  head_next;
    logic [fbfl_pkg::COUNT_W-1:0] used_reg;
    logic [fbfl_pkg::COUNT_W-1:0] used_next;
    logic                         ready_reg;
    logic [fbfl_pkg::ADDR_W-1:0]  walk_reg;

    logic                         pend_valid_reg;
    logic                         pend_ok_reg;
    logic [fbfl_pkg::IDX_W-1:0]   pend_grant_reg;
    logic [fbfl_pkg::COUNT_W-1:0] pend_used_reg;

    logic                         out_valid_reg;
    logic                         out_ok_reg;
    logic [fbfl_pkg::IDX_W-1:0]   out_grant_reg;
    logic [fbfl_pkg::COUNT_W-1:0] out_used_reg;

    logic [fbfl_pkg::ADDR_W-1:0]  ram_addr;
    logic [fbfl_pkg::LINK_W-1:0]  ram_wdata;
    logic [fbfl_pkg::LINK_W-1:0]  ram_rdata;

    logic [fbfl_pkg::CFG_W-1:0]   blocks_eff;
    logic [fbfl_pkg::CFG_W-1:0]   last_block;
    logic                         walk_last;
    logic                         slot_free;
    logic [fbfl_pkg::LINK_W-1:0]  walk_link;

    // clamp the pool size to one block at least and the depth at most
    always_comb
    begin
        if (pool_blocks == '0)
        begin
            blocks_eff = fbfl_pkg::CFG_W'(1);
        end
        else if (pool_blocks > fbfl_pkg::CFG_W'(fbfl_pkg::POOL_CAP))
        begin
            blocks_eff = fbfl_pkg::CFG_W'(fbfl_pkg::POOL_CAP);
        end
        else
        begin
            blocks_eff = pool_blocks;
        end
    end

    assign last_block = blocks_eff - fbfl_pkg::CFG_W'(1);
    assign walk_last  = (fbfl_pkg::LINK_W'(walk_reg) == fbfl_pkg::LINK_W'(last_block));
    assign walk_link  = walk_last ? fbfl_pkg::LINK_NULL
                                  : fbfl_pkg::LINK_W'(walk_reg) + fbfl_pkg::LINK_W'(1);
    assign slot_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.addr_sel)
            fbfl_pkg::ADDR_HEAD: ram_addr = fbfl_pkg::ADDR_W'(head_reg);
            fbfl_pkg::ADDR_IDX:  ram_addr = fbfl_pkg::ADDR_W'(idx_reg);
            fbfl_pkg::ADDR_WALK: ram_addr = walk_reg;
            default:             ram_addr = fbfl_pkg::ADDR_W'(head_reg);
        endcase
        case (cmd.wdata_sel)
            fbfl_pkg::WD_RDATA: ram_wdata = ram_rdata;
            fbfl_pkg::WD_NULL:  ram_wdata = fbfl_pkg::LINK_NULL;
            fbfl_pkg::WD_IDX:   ram_wdata = fbfl_pkg::LINK_W'(idx_reg);
            fbfl_pkg::WD_WALK:  ram_wdata = walk_link;
            default:            ram_wdata = ram_rdata;
        endcase
        case (cmd.head_sel)
            fbfl_pkg::HEAD_HOLD:  head_next = head_reg;
            fbfl_pkg::HEAD_RDATA: head_next = ram_rdata;
            fbfl_pkg::HEAD_IDX:   head_next = fbfl_pkg::LINK_W'(idx_reg);
            fbfl_pkg::HEAD_ZERO:  head_next = '0;
            default:              head_next = head_reg;
        endcase
        used_next = used_reg;
        if (cmd.cnt_inc && (used_reg != fbfl_pkg::COUNT_MAX))
        begin
            used_next = used_reg + fbfl_pkg::COUNT_W'(1);
        end
        else if (cmd.cnt_dec && (used_reg != '0))
        begin
            used_next = used_reg - fbfl_pkg::COUNT_W'(1);
        end
    end

    fbfl_ram #(
        .WIDTH (fbfl_pkg::LINK_W),
        .DEPTH (fbfl_pkg::POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= fbfl_pkg::LINK_NULL;
            used_reg       <= '0;
            ready_reg      <= 1'b0;
            walk_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            used_reg <= used_next;
            if (cmd.set_ready)
            begin
                ready_reg <= 1'b1;
            end
            if (cmd.capture)
            begin
                walk_reg <= '0;
            end
            else if (cmd.walk_inc)
            begin
                walk_reg <= walk_reg + fbfl_pkg::ADDR_W'(1);
            end
            // advance the pending word when the output slot frees up
            if (cmd.finish)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_valid_reg && slot_free)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_valid_reg && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            idx_reg <= block_index;
        end
        if (cmd.finish)
        begin
            pend_ok_reg    <= cmd.ok;
            pend_grant_reg <= cmd.grant ? fbfl_pkg::IDX_W'(head_reg) : '0;
            pend_used_reg  <= used_next;
        end
        if (pend_valid_reg && slot_free)
        begin
            out_ok_reg    <= pend_ok_reg;
            out_grant_reg <= pend_grant_reg;
            out_used_reg  <= pend_used_reg;
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.pool_ready = ready_reg;
        stat.head_valid = (head_reg < fbfl_pkg::LINK_NULL);
        stat.head_null  = (head_reg == fbfl_pkg::LINK_NULL);
        stat.idx_valid  = (32'(idx_reg) < 32'(fbfl_pkg::POOL_DEPTH));
        stat.walk_last  = walk_last;
        stat.pend_full  = pend_valid_reg;
        stat.slot_free  = slot_free;
    end

    assign out_valid     = out_valid_reg;
    assign ok            = out_ok_reg;
    assign granted_index = out_grant_reg;
    assign used_blocks   = out_used_reg;

endmodule

@@ hdl/fixed_block_free_list_allocator.sv @@
// Top level of the fixed-size block free-list allocator
//
//  channel  | handshake            | words
//  ---------+----------------------+-----------------------------------
//  in       | in_valid / in_ready  | op, block_index
//  out      | out_valid / out_ready| ok, granted_index, used_blocks
//  config   | APB write, pready=1  | pool_blocks at byte address 0
//
// Allocate and a repeated initialise use the idle and execute states, free adds
// a write state unless the list is empty, and a first initialise walks the
// clamped pool_blocks entries in an init state: every step is bound by the
// single port of the link RAM. The link RAM is not cleared at reset: allocate
// and free fail until an initialise, yet the block accepts at once. A stalled
// output holds one word, a second waits in a pending stage, and a new word is
// accepted in the idle state when that pending stage is free or draining.
`include "assert_macros.svh"

module fixed_block_free_list_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fbfl_pkg::OP_W-1:0]           op,
    input  logic [fbfl_pkg::IDX_W-1:0]          block_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic [fbfl_pkg::IDX_W-1:0]          granted_index,
    output logic [fbfl_pkg::COUNT_W-1:0]        used_blocks,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbfl_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    fbfl_pkg::dp_cmd_t  cmd;
    fbfl_pkg::dp_stat_t stat;

    logic [fbfl_pkg::CFG_W-1:0] pool_blocks_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_blocks_reg <= fbfl_pkg::POOL_BLOCKS_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == fbfl_pkg::REG_POOL_BLOCKS))
        begin
            pool_blocks_reg <= pwdata[fbfl_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fbfl_pkg::REG_POOL_BLOCKS: prdata = 32'(pool_blocks_reg);
            default:                   prdata = '0;
        endcase
    end

    fbfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbfl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .block_index   (block_index),
        .pool_blocks   (pool_blocks_reg),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .ok            (ok),
        .granted_index (granted_index),
        .used_blocks   (used_blocks)
    );

    `FBFL_ASSERT_IMP(a_finish_pend_free, clk, rst_n, cmd.finish, !stat.pend_full, "result finished while pending stage full")
    `FBFL_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "new word accepted while previous one still in work")
    `FBFL_ASSERT_IMP(a_write_only_busy, clk, rst_n, cmd.ram_we, !in_ready, "link RAM written while idle")
    `FBFL_ASSERT_IMP(a_grant_valid_head, clk, rst_n, cmd.finish && cmd.grant, stat.pool_ready && stat.head_valid, "block granted from an empty or unset pool")

endmodule
